FILE: rtl/spm_pkg.sv
// Shared types and constants for the storage performance monitor.
// Used by spm_front, spm_back and storage_perf_monitor_unit.
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;
	localparam logic [1:0] KIND_EVENT = 2'd0;
	localparam logic [1:0] KIND_GC    = 2'd1;
	localparam logic [1:0] KIND_LAT   = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic [1:0] GRP_EVENT = 2'd0;
	localparam logic [1:0] GRP_MEAN  = 2'd1;
	localparam logic [1:0] GRP_URD   = 2'd2;
	localparam logic [1:0] GRP_UWR   = 2'd3;

	localparam logic [2:0] RT_READ     = 3'd0;
	localparam logic [2:0] RT_WRITE    = 3'd1;
	localparam logic [2:0] RT_RMW_RD   = 3'd2;
	localparam logic [2:0] RT_RMW_WR   = 3'd3;
	localparam logic [2:0] RT_GC_ERASE = 3'd6;
	localparam logic [2:0] RT_OTHER    = 3'd7;
	localparam logic [2:0] GC_SLOT     = 3'd7;

	localparam int NUM_EVENTS = 8;
	localparam int NUM_MEANS  = 12;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  req_class;
		logic [2:0]  channel;
		logic [2:0]  chip;
		logic [1:0]  stage;
		logic        gc_sample;
		logic [31:0] latency_us;
		logic [1:0]  stat_group;
		logic [5:0]  stat_index;
	} in_word_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        out_of_range;
	} out_word_t;

	// Decoded command passed from front to back.
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_EVENT  = 3'd1;
	localparam logic [2:0] OP_MEAN   = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  ev_slot;
		logic        unit_inc;
		logic        unit_wr;
		logic [11:0] unit;
		logic        flag;
		logic [3:0]  mean_slot;
		logic [2:0]  n_slot;
		logic [31:0] delta;
		logic [1:0]  group;
		logic [5:0]  index;
	} cmd_t;
endpackage
`default_nettype wire

FILE: rtl/spm_front.sv
// Front part: accepts input words, decodes them into commands for the back part.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spm_front #(
	parameter int NUM_UNITS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [3:0]       cpc,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire spm_pkg::in_word_t in_word,
	output logic                  cmd_valid,
	input  wire logic             cmd_stall,
	output spm_pkg::cmd_t         cmd_word
);
	spm_pkg::cmd_t c;
	logic [6:0] prod;
	logic [7:0] unit_full;
	logic full_q;
	spm_pkg::cmd_t cmd_q;

	always_comb begin
		prod = 7'(cpc * in_word.channel);
		unit_full = {1'b0, prod} + {5'd0, in_word.chip};
		c = '0;
		c.delta = in_word.latency_us;
		c.group = in_word.stat_group;
		c.index = in_word.stat_index;
		c.unit = 12'(unit_full);
		c.ev_slot = in_word.req_class;
		case (in_word.kind)
			spm_pkg::KIND_EVENT: begin
				if (in_word.req_class != spm_pkg::RT_OTHER) begin
					c.op = spm_pkg::OP_EVENT;
					if (in_word.req_class != spm_pkg::RT_GC_ERASE) begin
						if (32'(unit_full) < 32'(NUM_UNITS)) begin
							c.unit_inc = 1'b1;
							c.unit_wr = in_word.req_class[0];
						end else begin
							c.flag = 1'b1;
						end
					end
				end
			end
			spm_pkg::KIND_GC: begin
				c.op = spm_pkg::OP_EVENT;
				c.ev_slot = spm_pkg::GC_SLOT;
			end
			spm_pkg::KIND_LAT: begin
				if (in_word.stage != 2'd3) begin
					if (in_word.gc_sample) begin
						c.op = spm_pkg::OP_MEAN;
						c.n_slot = spm_pkg::GC_SLOT;
						c.mean_slot = 4'(9 + in_word.stage);
					end else if (in_word.req_class == spm_pkg::RT_READ ||
							in_word.req_class == spm_pkg::RT_WRITE) begin
						c.op = spm_pkg::OP_MEAN;
						c.n_slot = in_word.req_class;
						c.mean_slot = 4'(in_word.req_class[0] ? 3 + in_word.stage
							: in_word.stage);
					end else if ((in_word.req_class == spm_pkg::RT_RMW_RD &&
							in_word.stage != 2'd2) ||
							(in_word.req_class == spm_pkg::RT_RMW_WR &&
							in_word.stage == 2'd2)) begin
						c.op = spm_pkg::OP_MEAN;
						c.n_slot = spm_pkg::RT_RMW_RD;
						c.mean_slot = 4'(6 + in_word.stage);
					end
				end
			end
			default: c.op = spm_pkg::OP_READ;
		endcase
	end

	// one-entry queue
	assign in_stall = full_q && cmd_stall;
	assign cmd_valid = full_q;
	assign cmd_word = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			full_q <= 1'b1;
		end else if (!cmd_stall) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= c;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/spm_back.sv
// Back part: counter storage, unit memories, serial running-mean divider, reads.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spm_back #(
	parameter int NUM_UNITS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire spm_pkg::cmd_t     cmd_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output spm_pkg::out_word_t     out_word
);
	localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int CW = $clog2(NUM_UNITS + 1);
	localparam logic [3:0] ST_IDLE = 4'd0, ST_URD = 4'd1, ST_UWB = 4'd2,
		ST_MUL0 = 4'd3, ST_MUL1 = 4'd4, ST_MUL2 = 4'd5, ST_DIV = 4'd6,
		ST_RRD = 4'd7, ST_RDONE = 4'd8, ST_OUT = 4'd9, ST_CLR = 4'd10;

	logic [3:0] state_q;
	logic [63:0] ev_q [spm_pkg::NUM_EVENTS];
	logic [31:0] mean_q [spm_pkg::NUM_MEANS];
	logic [63:0] urd_mem [NUM_UNITS];
	logic [63:0] uwr_mem [NUM_UNITS];
	logic [63:0] urd_rd_q, uwr_rd_q;
	logic [CW-1:0] clr_q;
	spm_pkg::cmd_t cmd_q;
	logic out_full_q;
	spm_pkg::out_word_t out_q;
	logic [96:0] rem_q;
	logic [64:0] den_q;
	logic [31:0] quo_q;
	logic [5:0] bit_q;
	logic [63:0] p0_q, p1_q;
	logic [95:0] num;
	logic [96:0] trial;
	logic [UW-1:0] uaddr;
	logic mem_we, mem_wsel;
	logic [UW-1:0] mem_waddr;
	logic [63:0] mem_wdata;

	assign uaddr = (cmd_q.op == spm_pkg::OP_READ) ? UW'(cmd_q.index) : UW'(cmd_q.unit);
	assign cmd_stall = (state_q != ST_IDLE) || out_full_q;
	assign out_valid = out_full_q;
	assign out_word = out_q;
	assign num = {32'd0, p0_q} + {p1_q, 32'd0} + {64'd0, cmd_q.delta};
	assign trial = rem_q - ({32'd0, den_q} << bit_q[4:0]);

	always_comb begin
		mem_we = 1'b0;
		mem_wsel = cmd_q.unit_wr;
		mem_waddr = UW'(cmd_q.unit);
		mem_wdata = (cmd_q.unit_wr ? uwr_rd_q : urd_rd_q) + 64'd1;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_waddr = UW'(clr_q);
			mem_wdata = '0;
		end else if (state_q == ST_UWB) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && (state_q == ST_CLR || !mem_wsel)) urd_mem[mem_waddr] <= mem_wdata;
		if (mem_we && (state_q == ST_CLR || mem_wsel)) uwr_mem[mem_waddr] <= mem_wdata;
		urd_rd_q <= urd_mem[uaddr];
		uwr_rd_q <= uwr_mem[uaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			out_full_q <= 1'b0;
			for (int i = 0; i < spm_pkg::NUM_EVENTS; i++) ev_q[i] <= '0;
			for (int i = 0; i < spm_pkg::NUM_MEANS; i++) mean_q[i] <= '0;
		end else begin
			if (out_full_q && !out_stall) out_full_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(NUM_UNITS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid && !out_full_q) begin
						cmd_q <= cmd_word;
						out_q <= '{read_data: 64'd0, out_of_range: cmd_word.flag};
						case (cmd_word.op)
							spm_pkg::OP_EVENT: begin
								ev_q[cmd_word.ev_slot] <= ev_q[cmd_word.ev_slot] + 64'd1;
								state_q <= cmd_word.unit_inc ? ST_URD : ST_OUT;
							end
							spm_pkg::OP_MEAN: state_q <= ST_MUL0;
							spm_pkg::OP_READ: state_q <= ST_RRD;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_URD: state_q <= ST_UWB;
				ST_UWB: state_q <= ST_OUT;
				ST_MUL0: begin
					p0_q <= 64'(mean_q[cmd_q.mean_slot]) * 64'(ev_q[cmd_q.n_slot][31:0]);
					p1_q <= 64'(mean_q[cmd_q.mean_slot]) * 64'(ev_q[cmd_q.n_slot][63:32]);
					den_q <= {1'b0, ev_q[cmd_q.n_slot]} + 65'd1;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					rem_q <= {1'b0, num};
					quo_q <= '0;
					bit_q <= 6'd31;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!trial[96]) begin
						rem_q <= trial;
						quo_q[bit_q[4:0]] <= 1'b1;
					end
					if (bit_q == 6'd0) state_q <= ST_MUL2;
					bit_q <= bit_q - 6'd1;
				end
				ST_MUL2: begin
					mean_q[cmd_q.mean_slot] <= quo_q;
					state_q <= ST_OUT;
				end
				ST_RRD: state_q <= ST_RDONE;
				ST_RDONE: begin
					case (cmd_q.group)
						spm_pkg::GRP_EVENT: begin
							if (cmd_q.index < 6'(spm_pkg::NUM_EVENTS)) begin
								out_q.read_data <= ev_q[cmd_q.index[2:0]];
							end else begin
								out_q.out_of_range <= 1'b1;
							end
						end
						spm_pkg::GRP_MEAN: begin
							if (cmd_q.index < 6'(spm_pkg::NUM_MEANS)) begin
								out_q.read_data <= 64'(mean_q[cmd_q.index[3:0]]);
							end else begin
								out_q.out_of_range <= 1'b1;
							end
						end
						default: begin
							if (32'(cmd_q.index) < 32'(NUM_UNITS)) begin
								out_q.read_data <= (cmd_q.group == spm_pkg::GRP_URD) ?
									urd_rd_q : uwr_rd_q;
							end else begin
								out_q.out_of_range <= 1'b1;
							end
						end
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_full_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_only_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_full_q) |-> $past(state_q) == ST_OUT)
		else $error("result without work");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> cmd_stall)
		else $error("command taken while busy");
	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> bit_q < 6'd32)
		else $error("divider step out of range");
endmodule
`default_nettype wire

FILE: rtl/storage_perf_monitor_unit.sv
// Storage performance monitor top level: front decoder, queue and back engine.
// Depends on spm_pkg, spm_front and spm_back.
// Usage: input words (in_valid/in_word/in_stall) carry event, gc, latency or
// statistic-read commands; every word yields one output word
// (out_valid/out_word/out_stall). Counters are 64 bit and wrap.
// Gc, erase, other and out-of-range events go straight to the output stage;
// unit events and reads first read a unit memory; latency samples pass the
// 32-step restoring divider of the running mean.
// One word is in the back engine at a time; the front holds one more. The
// back takes its next word in the cycle after the output word leaves.
// Reset: counters and means clear at once; the unit counter memories are
// swept one entry a cycle, all NUM_CHANNELS*NUM_CHIPS of them, taking no word.
// chips_per_channel resets to 8 and is written through cfg_we/cfg_data; the
// user must write it only while idle, which the block does not enforce.
// A stalled output holds its word; the back engine then waits and the front
// queue fills, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module storage_perf_monitor_unit #(
	parameter int NUM_CHANNELS = 8,
	parameter int NUM_CHIPS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [3:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire spm_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output spm_pkg::out_word_t      out_word
);
	localparam int NUM_UNITS = NUM_CHANNELS * NUM_CHIPS;
	logic [3:0] cpc_q;
	logic cmd_valid, cmd_stall;
	spm_pkg::cmd_t cmd_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cpc_q <= 4'd8;
		else if (cfg_we) cpc_q <= cfg_data;
	end

	spm_front #(.NUM_UNITS(NUM_UNITS)) u_front (
		.clk, .arst_n, .cpc(cpc_q), .in_valid, .in_stall, .in_word,
		.cmd_valid, .cmd_stall, .cmd_word
	);

	spm_back #(.NUM_UNITS(NUM_UNITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_stall, .cmd_word,
		.out_valid, .out_stall, .out_word
	);
endmodule
`default_nettype wire
